>>> sv/tmse_pkg.sv
`default_nettype none
package tmse_pkg;

  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int SYM_W      = 8;
  localparam int ST_W       = 8;
  localparam int CELL_IDX_W = 10;
  localparam int HEAD_POS_W = 10;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND_RULE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND_CELL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START_RUN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STEP        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_CELL   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_RULE     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_LEFT_EDGE   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_TAPE_OVF    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_STORE_FULL  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_NOT_RUNNING = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ST_W-1:0]       state_code;
    logic [SYM_W-1:0]      read_symbol;
    logic [SYM_W-1:0]      write_symbol;
    logic                  move_right;
    logic [ST_W-1:0]       next_state;
    logic [CELL_IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ST_W-1:0]       cur_state;
    logic [HEAD_POS_W-1:0] head_pos;
    logic [SYM_W-1:0]      cell_symbol;
    logic                  halted;
  } rsp_t;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic [SYM_W-1:0] rd;
    logic [SYM_W-1:0] wr;
    logic             right;
    logic [ST_W-1:0]  nx;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

endpackage
`default_nettype wire

>>> sv/tmse_ram.sv
`default_nettype none
module tmse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/turing_machine_step_engine_core.sv
`default_nettype none
// Single-tape Turing machine engine. A request is taken when start is high and busy is low;
// its one result shows on out_rsp for exactly one cycle with out_valid high and cannot be
// held off, so the receiver must take it then. Appending a rule or a cell, starting a run,
// unused kinds and a step while not running are answered from idle, the result showing in
// the cycle after the request is taken; reading a cell waits in S_CREAD for the registered
// tape memory read. A step does a registered tape read of the cell under the head in
// S_TREAD; S_SCAN then compares one rule per cycle, in order, up to the first match (all
// loaded rules when none matches, at most RULES_DEPTH), as rule memory has one read port.
// The next request may be given in the cycle the result is shown. Rules and tape cells
// are held in memories with no reset; only entries below the loaded counts are read.
module turing_machine_step_engine_core
  import tmse_pkg::*;
#(
  parameter int RULES_DEPTH = 64,
  parameter int TAPE_DEPTH  = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire req_t in_req,
  output logic      out_valid,
  output rsp_t      out_rsp
);

  localparam int RAW = (RULES_DEPTH > 1) ? $clog2(RULES_DEPTH) : 1;
  localparam int CW  = $clog2(RULES_DEPTH + 1);
  localparam int TAW = $clog2(TAPE_DEPTH);
  localparam int LW  = $clog2(TAPE_DEPTH + 1);
  localparam int TCW = (LW > CELL_IDX_W) ? LW : CELL_IDX_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TREAD = 4'b0010,
    S_SCAN  = 4'b0100,
    S_CREAD = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  req_t            req_r, req_nxt;
  logic            running_r, running_nxt;
  logic [ST_W-1:0] mstate_r, mstate_nxt;
  logic [TAW-1:0]  head_r, head_nxt;
  logic [LW-1:0]   tape_len_r, tape_len_nxt;
  logic [SYM_W-1:0] blank_r, blank_nxt;
  logic [CW-1:0]   rule_cnt_r, rule_cnt_nxt;
  logic [RAW-1:0]  idx_r, idx_nxt;
  logic [SYM_W-1:0] under_r, under_nxt;
  logic            out_valid_r, out_valid_nxt;
  rsp_t            out_rsp_r, out_rsp_nxt;

  logic            rule_we;
  logic [RAW-1:0]  rule_waddr, rule_raddr;
  logic [RULE_W-1:0] rule_wdata, rule_rdata;
  logic            tape_we;
  logic [TAW-1:0]  tape_waddr, tape_raddr;
  logic [SYM_W-1:0] tape_wdata, tape_rdata;

  rule_t           rule_q, rule_in;
  logic            accept, rule_hit, last_rule, head_in_tape, cidx_in_tape;
  logic [SYM_W-1:0] under_now;

  tmse_ram #(.DEPTH(RULES_DEPTH), .WIDTH(RULE_W)) u_rules (
    .clk     (clk),
    .we      (rule_we),
    .waddr   (rule_waddr),
    .wdata   (rule_wdata),
    .raddr   (rule_raddr),
    .rdata_r (rule_rdata)
  );

  tmse_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(SYM_W)) u_tape (
    .clk     (clk),
    .we      (tape_we),
    .waddr   (tape_waddr),
    .wdata   (tape_wdata),
    .raddr   (tape_raddr),
    .rdata_r (tape_rdata)
  );

  assign accept       = start && (state_r == S_IDLE);
  assign rule_q       = rule_t'(rule_rdata);
  assign rule_hit     = (rule_q.st == mstate_r) && (rule_q.rd == under_r);
  assign last_rule    = ((CW'(idx_r) + CW'(1)) == rule_cnt_r);
  assign head_in_tape = (LW'(head_r) < tape_len_r);
  assign cidx_in_tape = (TCW'(req_r.cell_index) < TCW'(tape_len_r));
  assign under_now    = head_in_tape ? tape_rdata : blank_r;

  assign rule_in.st    = in_req.state_code;
  assign rule_in.rd    = in_req.read_symbol;
  assign rule_in.wr    = in_req.write_symbol;
  assign rule_in.right = in_req.move_right;
  assign rule_in.nx    = in_req.next_state;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    running_nxt   = running_r;
    mstate_nxt    = mstate_r;
    head_nxt      = head_r;
    tape_len_nxt  = tape_len_r;
    blank_nxt     = blank_r;
    rule_cnt_nxt  = rule_cnt_r;
    idx_nxt       = idx_r;
    under_nxt     = under_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    rule_we    = 1'b0;
    rule_waddr = RAW'(rule_cnt_r);
    rule_wdata = rule_in;
    rule_raddr = '0;
    tape_we    = 1'b0;
    tape_waddr = TAW'(tape_len_r);
    tape_wdata = in_req.read_symbol;
    tape_raddr = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_req.kind == KIND_READ_CELL) begin
          tape_raddr = TAW'(in_req.cell_index);
        end
        if (accept) begin
          req_nxt = in_req;
          out_rsp_nxt.status      = STAT_OK;
          out_rsp_nxt.cell_symbol = '0;
          case (in_req.kind)
            KIND_APPEND_RULE: begin
              if (rule_cnt_r == CW'(RULES_DEPTH)) begin
                out_rsp_nxt.status = STAT_STORE_FULL;
              end else begin
                rule_we      = 1'b1;
                rule_cnt_nxt = rule_cnt_r + CW'(1);
              end
            end
            KIND_APPEND_CELL: begin
              if (tape_len_r == LW'(TAPE_DEPTH)) begin
                out_rsp_nxt.status = STAT_TAPE_OVF;
              end else begin
                tape_we      = 1'b1;
                tape_len_nxt = tape_len_r + LW'(1);
                blank_nxt    = in_req.read_symbol;
              end
            end
            KIND_START_RUN: begin
              mstate_nxt  = in_req.state_code;
              head_nxt    = '0;
              running_nxt = 1'b1;
            end
            KIND_STEP: begin
              if (!running_r) begin
                out_rsp_nxt.status = STAT_NOT_RUNNING;
              end else begin
                state_nxt = S_TREAD;
              end
            end
            KIND_READ_CELL: begin
              state_nxt = S_CREAD;
            end
            default: begin
            end
          endcase
          out_valid_nxt = (state_nxt == S_IDLE);
        end
      end

      S_TREAD: begin
        under_nxt  = under_now;
        rule_raddr = '0;
        idx_nxt    = '0;
        if (rule_cnt_r == '0) begin
          running_nxt             = 1'b0;
          out_rsp_nxt.status      = STAT_NO_RULE;
          out_rsp_nxt.cell_symbol = under_now;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        rule_raddr = idx_r + RAW'(1);
        if (rule_hit) begin
          // head never passes the tape length, so a write only overwrites or extends by one
          tape_we    = 1'b1;
          tape_waddr = head_r;
          tape_wdata = rule_q.wr;
          if (LW'(head_r) == tape_len_r) begin
            tape_len_nxt = tape_len_r + LW'(1);
          end
          mstate_nxt              = rule_q.nx;
          out_rsp_nxt.status      = STAT_OK;
          out_rsp_nxt.cell_symbol = rule_q.wr;
          if (rule_q.right) begin
            if (head_r == TAW'(TAPE_DEPTH - 1)) begin
              running_nxt        = 1'b0;
              out_rsp_nxt.status = STAT_TAPE_OVF;
            end else begin
              head_nxt = head_r + TAW'(1);
            end
          end else begin
            if (head_r == '0) begin
              running_nxt        = 1'b0;
              out_rsp_nxt.status = STAT_LEFT_EDGE;
            end else begin
              head_nxt = head_r - TAW'(1);
            end
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (last_rule) begin
          running_nxt             = 1'b0;
          out_rsp_nxt.status      = STAT_NO_RULE;
          out_rsp_nxt.cell_symbol = under_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end else begin
          idx_nxt = idx_r + RAW'(1);
        end
      end

      S_CREAD: begin
        out_rsp_nxt.status      = STAT_OK;
        out_rsp_nxt.cell_symbol = cidx_in_tape ? tape_rdata : blank_r;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_rsp_nxt.cur_state = mstate_nxt;
    out_rsp_nxt.head_pos  = HEAD_POS_W'(head_nxt);
    out_rsp_nxt.halted    = !running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      mstate_r    <= '0;
      head_r      <= '0;
      tape_len_r  <= '0;
      blank_r     <= '0;
      rule_cnt_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      mstate_r    <= mstate_nxt;
      head_r      <= head_nxt;
      tape_len_r  <= tape_len_nxt;
      blank_r     <= blank_nxt;
      rule_cnt_r  <= rule_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    under_r   <= under_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_done_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("sequencer returned to idle without a result");

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted request neither answered nor in progress");

  a_head_in_tape: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(head_r) <= tape_len_r)
    else $error("head beyond tape length, gap fill would be needed");

  a_scan_has_rules: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((rule_cnt_r != '0) && running_r))
    else $error("rule scan with empty store or stopped machine");

endmodule
`default_nettype wire
